// ===== rtl/core/mts_pkg.sv =====
`timescale 1ns / 1ps
// Mission time service package: codes, constants and shared controller/datapath types.
// No dependencies.
package mts_pkg;
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_TC = 2'd1;
  localparam logic [1:0] OP_PERIODIC = 2'd2;
  localparam logic [7:0] FN_PERIODIC = 8'h00;
  localparam logic [7:0] FN_SET = 8'h01;
  localparam logic [7:0] FN_ADJUST = 8'h02;
  localparam logic [7:0] FN_PING = 8'hFF;
  localparam logic [2:0] FULL_PAYLOAD = 3'd7;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD_LEN = 2'd1;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
  localparam int FINE_SHIFT = 16;
  localparam int TPS_W = 20;
  localparam int SEQ_W = 14;
  localparam logic [1:0] CFG_ENABLED = 2'd0;
  localparam logic [1:0] CFG_CHANNEL = 2'd1;
  localparam logic [1:0] CFG_TPS = 2'd2;

  typedef struct packed {
    logic tick;
    logic load_set;
    logic load_adjust;
    logic start_div;
    logic start_fine;
    logic finish_report;
  } mts_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
  } mts_status_t;
endpackage

// ===== rtl/core/mission_time_service.sv =====
`timescale 1ns / 1ps
// Mission time service: tick counter plus signed offset, CCSDS 32.16 time reports.
// A tick updates the counter at accept; an error result is valid the cycle after accept;
// set/adjust run the serial multiply (S_MUL) and then S_OUT before the result; a report
// waits on two 64-step passes of the bit-serial divider (seconds, then fine fraction).
// A pending result holds off the input until it is taken.
// Depends on mts_pkg, mts_ctrl, mts_datapath.
module mission_time_service import mts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  func_code_i,
  input  logic [2:0]  payload_length_i,
  input  logic [31:0] seconds_value_i,
  input  logic [15:0] fine_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        report_valid_o,
  output logic [7:0]  report_func_o,
  output logic [31:0] report_seconds_o,
  output logic [15:0] report_fine_o,
  output logic [13:0] report_sequence_o,
  output logic [2:0]  report_channel_o,
  output logic [1:0]  status_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i
);
  logic enabled_q;
  logic [2:0] channel_q;
  logic [TPS_W-1:0] tps_q;
  mts_cmd_t cmd;
  mts_status_t dps;
  logic rep;
  logic [7:0] func;
  logic [31:0] secs;
  logic [15:0] fine;
  logic [SEQ_W-1:0] seq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      channel_q <= '0;
      tps_q <= TPS_W'(10000);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ENABLED: enabled_q <= cfg_data_i[0];
        CFG_CHANNEL: channel_q <= cfg_data_i[2:0];
        CFG_TPS: tps_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mts_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .operation_i, .func_code_i,
    .payload_length_i, .enabled_i(enabled_q), .out_ready_i, .out_valid_o,
    .report_o(rep), .func_o(func), .status_o, .cmd_o(cmd), .dp_status_i(dps)
  );

  mts_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(dps), .tps_i(tps_q),
    .seconds_i(seconds_value_i), .fine_i(fine_value_i),
    .seconds_o(secs), .fine_o(fine), .sequence_o(seq)
  );

  assign report_valid_o = rep;
  assign report_func_o = rep ? func : 8'd0;
  assign report_seconds_o = rep ? secs : 32'd0;
  assign report_fine_o = rep ? fine : 16'd0;
  assign report_sequence_o = rep ? seq - SEQ_W'(1) : '0;
  assign report_channel_o = rep ? channel_q : 3'd0;

`ifndef ASSERT_OFF
  a_no_accept_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input taken while result pending");
  a_ok_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && report_valid_o) |-> (status_o == ST_OK)) else $error("report with error");
  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.start_div, cmd.start_fine, cmd.finish_report}))
    else $error("conflicting commands");
`endif
endmodule

// ===== rtl/core/mts_datapath.sv =====
`timescale 1ns / 1ps
// Mission time datapath: tick counter, offset, sequence, serial multiply and divide.
// Depends on mts_pkg.
module mts_datapath import mts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mts_cmd_t          cmd_i,
  output mts_status_t       status_o,
  input  logic [TPS_W-1:0]  tps_i,
  input  logic [31:0]       seconds_i,
  input  logic [15:0]       fine_i,
  output logic [31:0]       seconds_o,
  output logic [15:0]       fine_o,
  output logic [SEQ_W-1:0]  sequence_o
);
  logic [63:0] uptime_q, uptime_d, offset_q, offset_d;
  logic [SEQ_W-1:0] seq_q, seq_d;
  logic [TPS_W-1:0] tps;
  // multiply: set/adjust delta computed serially, seconds part then fine part
  logic [1:0] mstep_q, mstep_d;
  logic mbusy_q, mbusy_d, madj_q, madj_d;
  logic [63:0] macc_q, macc_d;
  logic [31:0] sarg_q, sarg_d;
  logic [15:0] farg_q, farg_d;
  logic [63:0] mprod;
  logic [63:0] fprod_s, fq;
  // divide: 64-bit restoring divider, one bit a cycle
  logic [63:0] quo_q, quo_d;
  logic [TPS_W:0] rem_q, rem_d;
  logic [6:0] dcnt_q, dcnt_d;
  logic dbusy_q, dbusy_d, neg_q, neg_d;
  logic [TPS_W+1:0] trial;
  logic [31:0] sec_q, sec_d;
  logic [15:0] fin_q, fin_d;
  logic [63:0] now;

  assign tps = (tps_i == '0) ? TPS_W'(1) : tps_i;
  assign now = uptime_q + offset_q;

  always_comb begin
    mprod = '0;
    fprod_s = '0;
    fq = '0;
    if (mstep_q == 2'd0) begin
      if (madj_q) mprod = 64'($signed(sarg_q) * $signed({1'b0, tps}));
      else mprod = 64'(sarg_q * tps);
    end else begin
      if (madj_q) begin
        fprod_s = 64'($signed(farg_q) * $signed({1'b0, tps}));
        fq = fprod_s[63] ? -((-fprod_s) >> FINE_SHIFT) : (fprod_s >> FINE_SHIFT);
      end else begin
        fprod_s = 64'(farg_q * tps);
        fq = fprod_s >> FINE_SHIFT;
      end
      mprod = fq;
    end
  end

  assign trial = {rem_q, quo_q[63]} - {2'b00, tps};

  always_comb begin
    uptime_d = uptime_q;
    offset_d = offset_q;
    seq_d = seq_q;
    mstep_d = mstep_q;
    mbusy_d = mbusy_q;
    madj_d = madj_q;
    macc_d = macc_q;
    sarg_d = sarg_q;
    farg_d = farg_q;
    quo_d = quo_q;
    rem_d = rem_q;
    dcnt_d = dcnt_q;
    dbusy_d = dbusy_q;
    neg_d = neg_q;
    sec_d = sec_q;
    fin_d = fin_q;
    if (cmd_i.tick) uptime_d = uptime_q + 64'd1;
    if (cmd_i.load_set || cmd_i.load_adjust) begin
      mbusy_d = 1'b1;
      mstep_d = 2'd0;
      madj_d = cmd_i.load_adjust;
      macc_d = '0;
      sarg_d = seconds_i;
      farg_d = fine_i;
    end else if (mbusy_q) begin
      macc_d = macc_q + mprod;
      mstep_d = mstep_q + 2'd1;
      if (mstep_q == 2'd1) begin
        mbusy_d = 1'b0;
        if (madj_q) offset_d = offset_q + macc_q + mprod;
        else offset_d = macc_q + mprod - uptime_q;
      end
    end
    if (cmd_i.start_div) begin
      neg_d = now[63];
      quo_d = now;
      rem_d = '0;
      dcnt_d = 7'd64;
      dbusy_d = 1'b1;
    end else if (cmd_i.start_fine) begin
      sec_d = quo_q[31:0];
      quo_d = 64'(rem_q[TPS_W-1:0]) << FINE_SHIFT;
      rem_d = '0;
      dcnt_d = 7'd64;
      dbusy_d = 1'b1;
    end else if (dbusy_q) begin
      if (!trial[TPS_W+1]) begin
        rem_d = trial[TPS_W:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[TPS_W-1:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
      dcnt_d = dcnt_q - 7'd1;
      if (dcnt_q == 7'd1) dbusy_d = 1'b0;
    end
    if (cmd_i.finish_report) begin
      fin_d = neg_q ? 16'd0 : quo_q[15:0];
      if (neg_q) sec_d = '0;
      seq_d = seq_q + SEQ_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uptime_q <= '0;
      offset_q <= '0;
      seq_q <= '0;
      mbusy_q <= 1'b0;
      dbusy_q <= 1'b0;
      mstep_q <= '0;
      dcnt_q <= '0;
    end else begin
      uptime_q <= uptime_d;
      offset_q <= offset_d;
      seq_q <= seq_d;
      mbusy_q <= mbusy_d;
      dbusy_q <= dbusy_d;
      mstep_q <= mstep_d;
      dcnt_q <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    madj_q <= madj_d;
    macc_q <= macc_d;
    sarg_q <= sarg_d;
    farg_q <= farg_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
    sec_q <= sec_d;
    fin_q <= fin_d;
  end

  assign status_o.mul_done = mbusy_q && (mstep_q == 2'd1);
  assign status_o.div_done = dbusy_q && (dcnt_q == 7'd1);
  assign seconds_o = sec_q;
  assign fine_o = fin_q;
  assign sequence_o = seq_q;
endmodule

// ===== rtl/core/mts_ctrl.sv =====
`timescale 1ns / 1ps
// Mission time controller: decodes words, sequences datapath, holds the result word.
// Depends on mts_pkg.
module mts_ctrl import mts_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       operation_i,
  input  logic [7:0]       func_code_i,
  input  logic [2:0]       payload_length_i,
  input  logic             enabled_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic             report_o,
  output logic [7:0]       func_o,
  output logic [1:0]       status_o,
  output mts_cmd_t         cmd_o,
  input  mts_status_t      dp_status_i
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL = 3'd1;
  localparam logic [2:0] S_DIV_SEC = 3'd2;
  localparam logic [2:0] S_DIV_FINE = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;

  logic [2:0] state_q, state_d;
  logic ovalid_q, ovalid_d, rep_q, rep_d;
  logic [7:0] func_q, func_d;
  logic [1:0] stat_q, stat_d;
  logic acc;

  assign in_ready_o = (state_q == S_IDLE) && !ovalid_q;
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    ovalid_d = ovalid_q;
    rep_d = rep_q;
    func_d = func_q;
    stat_d = stat_q;
    cmd_o = '0;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          rep_d = 1'b0;
          func_d = FN_PERIODIC;
          stat_d = ST_OK;
          unique case (operation_i)
            OP_TICK: cmd_o.tick = 1'b1;
            OP_PERIODIC: begin
              if (enabled_i) begin
                rep_d = 1'b1;
                cmd_o.start_div = 1'b1;
                state_d = S_DIV_SEC;
              end
            end
            OP_TC: begin
              if (payload_length_i == 3'd0) begin
                stat_d = ST_BAD_LEN;
                ovalid_d = 1'b1;
              end else if (func_code_i == FN_PING) begin
                rep_d = 1'b1;
                func_d = FN_PING;
                cmd_o.start_div = 1'b1;
                state_d = S_DIV_SEC;
              end else if (func_code_i == FN_SET || func_code_i == FN_ADJUST) begin
                if (payload_length_i < FULL_PAYLOAD) begin
                  stat_d = ST_BAD_LEN;
                  ovalid_d = 1'b1;
                end else begin
                  cmd_o.load_set = (func_code_i == FN_SET);
                  cmd_o.load_adjust = (func_code_i == FN_ADJUST);
                  state_d = S_MUL;
                end
              end else begin
                stat_d = ST_UNSUPPORTED;
                ovalid_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_MUL: if (dp_status_i.mul_done) state_d = S_OUT;
      S_DIV_SEC: begin
        if (dp_status_i.div_done) state_d = S_DIV_FINE;
      end
      S_DIV_FINE: begin
        cmd_o.start_fine = 1'b1;
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (dp_status_i.div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        cmd_o.finish_report = rep_q;
        ovalid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rep_q <= rep_d;
    func_q <= func_d;
    stat_q <= stat_d;
  end

  assign out_valid_o = ovalid_q;
  assign report_o = rep_q;
  assign func_o = func_q;
  assign status_o = stat_q;
endmodule

// ===== dv/tb_mission_time_service.sv =====
`timescale 1ns / 1ps
// Testbench for mission_time_service: directed and random ticks, telecommands and
// periodic requests, checked against a built-in time predictor. Depends on mts_pkg.
module tb_mission_time_service;
  import mts_pkg::*;

  typedef struct packed {
    logic        rvalid;
    logic [7:0]  func;
    logic [31:0] secs;
    logic [15:0] fine;
    logic [13:0] seq;
    logic [2:0]  chan;
    logic [1:0]  status;
  } time_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  operation_i = '0;
  logic [7:0]  func_code_i = '0;
  logic [2:0]  payload_length_i = '0;
  logic [31:0] seconds_value_i = '0;
  logic [15:0] fine_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        report_valid_o;
  logic [7:0]  report_func_o;
  logic [31:0] report_seconds_o;
  logic [15:0] report_fine_o;
  logic [13:0] report_sequence_o;
  logic [2:0]  report_channel_o;
  logic [1:0]  status_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [19:0] cfg_data_i = '0;

  mission_time_service dut (.*);

  logic [0:0]   m_enabled;
  logic [2:0]   m_channel;
  logic [19:0]  m_tps;
  logic [63:0]  m_uptime;
  logic [63:0]  m_offset;
  logic [13:0]  m_seq;
  time_report_t pending_reports[$];
  int           fail_count = 0;
  bit           calm = 1'b0;

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #200ms;
    $display("status: fail");
    $finish;
  end

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 34);
  endfunction

  function automatic time_report_t time_report(logic [7:0] fn);
    time_report_t r;
    logic [63:0] tps, now, rem;
    tps = (m_tps == 0) ? 64'd1 : 64'(m_tps);
    now = m_uptime + m_offset;
    r = '0;
    r.rvalid = 1'b1;
    r.func = fn;
    if (!now[63]) begin
      rem = now % tps;
      r.secs = 32'(now / tps);
      r.fine = 16'((rem << FINE_SHIFT) / tps);
    end
    r.seq = m_seq;
    r.chan = m_channel;
    r.status = ST_OK;
    m_seq = m_seq + 1'b1;
    return r;
  endfunction

  task automatic predict_time(logic [1:0] op, logic [7:0] fn, logic [2:0] plen,
                              logic [31:0] sv, logic [15:0] fv);
    time_report_t r;
    logic [63:0] tps;
    longint sd, fd;
    tps = (m_tps == 0) ? 64'd1 : 64'(m_tps);
    r = '0;
    if (op == OP_TICK) m_uptime = m_uptime + 1;
    else if (op == OP_PERIODIC) begin
      if (m_enabled) pending_reports.push_back(time_report(FN_PERIODIC));
    end else if (op == OP_TC) begin
      if (plen == 0) begin
        r.status = ST_BAD_LEN;
        pending_reports.push_back(r);
      end else if (fn == FN_PING) pending_reports.push_back(time_report(FN_PING));
      else if (fn == FN_SET || fn == FN_ADJUST) begin
        if (plen < FULL_PAYLOAD) r.status = ST_BAD_LEN;
        else if (fn == FN_SET)
          m_offset = 64'(sv) * tps + ((64'(fv) * tps) >> FINE_SHIFT) - m_uptime;
        else begin
          sd = longint'($signed(sv));
          fd = longint'($signed(fv));
          m_offset = m_offset + 64'(sd * longint'(tps) + (fd * longint'(tps)) / 65536);
        end
        pending_reports.push_back(r);
      end else begin
        r.status = ST_UNSUPPORTED;
        pending_reports.push_back(r);
      end
    end
  endtask

  // valid stays up after the accepting edge until the next word or an idle cycle
  task automatic send_word(logic [1:0] op, logic [7:0] fn, logic [2:0] plen,
                           logic [31:0] sv, logic [15:0] fv);
    while (idle_now()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    func_code_i <= fn;
    payload_length_i <= plen;
    seconds_value_i <= sv;
    fine_value_i <= fv;
    do @(posedge clk_i); while (!in_ready_o);
    predict_time(op, fn, plen, sv, fv);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0 && guard < 1000000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [19:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ENABLED: m_enabled = val[0];
      CFG_CHANNEL: m_channel = val[2:0];
      default: m_tps = val;
    endcase
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= !idle_now();
    if (out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected word");
        fail_count++;
      end else begin
        time_report_t e;
        e = pending_reports.pop_front();
        if (report_valid_o !== e.rvalid) begin
          $error("report_valid exp %0h got %0h", e.rvalid, report_valid_o); fail_count++;
        end
        if (report_func_o !== e.func) begin
          $error("report_func exp %0h got %0h", e.func, report_func_o); fail_count++;
        end
        if (report_seconds_o !== e.secs) begin
          $error("report_seconds exp %0h got %0h", e.secs, report_seconds_o); fail_count++;
        end
        if (report_fine_o !== e.fine) begin
          $error("report_fine exp %0h got %0h", e.fine, report_fine_o); fail_count++;
        end
        if (report_sequence_o !== e.seq) begin
          $error("report_sequence exp %0h got %0h", e.seq, report_sequence_o); fail_count++;
        end
        if (report_channel_o !== e.chan) begin
          $error("report_channel exp %0h got %0h", e.chan, report_channel_o); fail_count++;
        end
        if (status_o !== e.status) begin
          $error("status exp %0h got %0h", e.status, status_o); fail_count++;
        end
      end
    end
  end

  task automatic test_directed();
    send_word(OP_TC, FN_PING, 3'd1, '0, '0);
    send_word(OP_TICK, '0, '0, '0, '0);
    send_word(OP_PERIODIC, '0, '0, '0, '0);
    send_word(2'd3, 8'hFF, 3'd7, '1, '1);
    send_word(OP_TC, FN_SET, 3'd0, '1, '1);
    send_word(OP_TC, FN_SET, 3'd6, '1, '1);
    send_word(OP_TC, FN_ADJUST, 3'd3, '1, '1);
    send_word(OP_TC, 8'h55, 3'd7, '0, '0);
    send_word(OP_TC, FN_SET, 3'd7, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(OP_TC, FN_PING, 3'd7, '0, '0);
    send_word(OP_TC, FN_SET, 3'd7, 32'd0, 16'd0);
    send_word(OP_TC, FN_ADJUST, 3'd7, 32'hFFFF_FFFF, 16'h8000);
    send_word(OP_TC, FN_PING, 3'd7, '0, '0);
    send_word(OP_TC, FN_ADJUST, 3'd7, 32'h7FFF_FFFF, 16'h7FFF);
    send_word(OP_TC, FN_PING, 3'd2, '0, '0);
    send_word(OP_TC, 8'h00, 3'd7, '0, '0);
  endtask

  task automatic test_config_sweep();
    write_cfg(CFG_ENABLED, 20'd1);
    write_cfg(CFG_CHANNEL, 20'd7);
    write_cfg(CFG_TPS, 20'd1);
    send_word(OP_PERIODIC, '0, '0, '0, '0);
    send_word(OP_TICK, '0, '0, '0, '0);
    send_word(OP_PERIODIC, '0, '0, '0, '0);
    write_cfg(CFG_TPS, 20'd0);
    send_word(OP_TC, FN_PING, 3'd7, '0, '0);
    write_cfg(CFG_TPS, 20'hFFFFF);
    send_word(OP_TC, FN_SET, 3'd7, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(OP_PERIODIC, '0, '0, '0, '0);
  endtask

  task automatic test_random(int count);
    logic [1:0] op;
    logic [7:0] fn;
    logic [2:0] plen;
    int k;
    for (int i = 0; i < count; i++) begin
      calm = (i % 300) > 230;
      if (i % 230 == 0) begin
        write_cfg(CFG_ENABLED, 20'($urandom_range(3) != 0));
        write_cfg(CFG_CHANNEL, 20'($urandom_range(7)));
        case ($urandom_range(4))
          0: write_cfg(CFG_TPS, 20'd1);
          1: write_cfg(CFG_TPS, 20'd1000000);
          2: write_cfg(CFG_TPS, 20'($urandom));
          default: write_cfg(CFG_TPS, 20'($urandom_range(100000, 1)));
        endcase
      end
      k = $urandom_range(99);
      op = (k < 40) ? OP_TICK : (k < 70) ? OP_TC : (k < 97) ? OP_PERIODIC : 2'd3;
      k = $urandom_range(99);
      fn = (k < 30) ? FN_PING : (k < 55) ? FN_SET : (k < 85) ? FN_ADJUST : 8'($urandom);
      plen = ($urandom_range(9) < 7) ? FULL_PAYLOAD : 3'($urandom);
      send_word(op, fn, plen, $urandom, 16'($urandom));
    end
    calm = 1'b0;
  endtask

  initial begin
    m_enabled = 1'b0;
    m_channel = '0;
    m_tps = 20'd10000;
    m_uptime = '0;
    m_offset = '0;
    m_seq = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_sweep();
    test_random(1130);
    drain();
    if (fail_count == 0 && pending_reports.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/mts_pkg.sv
rtl/core/mts_datapath.sv
rtl/core/mts_ctrl.sv
rtl/core/mission_time_service.sv
dv/tb_mission_time_service.sv
